// ===== src/spc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the shaft park position controller.
// ----------------------------------------------------------------------------
package spc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BLADE_FOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIM = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_LIM   = 4'd7;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Half and quarter turn in 1/65536 rev, for two-blade folding
    localparam logic signed [16:0] HALF_TURN    = 17'sd32768;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;

    localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef struct packed {
        logic        blade_fold;
        logic [14:0] deadband;
        logic [14:0] hysteresis;
        logic [15:0] prop_gain;
        logic [15:0] damp_gain;
        logic [15:0] speed_max;
        logic [15:0] min_kick;
        logic [15:0] settle_pos_tol;
        logic [15:0] settle_vel_tol;
        logic [31:0] settle_hold_us;
        logic [15:0] trip_err;
        logic [31:0] trip_time_us;
    } spc_cfg_t;

    typedef struct packed {
        logic [15:0]        target_angle;
        logic [15:0]        measured_angle;
        logic signed [23:0] shaft_velocity;
        logic               encoder_ok;
        logic [15:0]        elapsed_us;
    } spc_in_t;

    // Between the tracking logic and the command shaping logic
    typedef struct packed {
        logic signed [32:0] prop_prod;
        logic signed [40:0] damp_prod;
        logic               blocked;
        dir_t               dir;
        logic               zero_cmd;
        logic signed [15:0] position_err;
        logic               settled;
        logic               loop_active;
        logic               tripped;
        logic [31:0]        trip_elapsed_us;
    } spc_mid_t;

    typedef struct packed {
        logic signed [16:0] speed_ref;
        logic signed [15:0] position_err;
        logic               settled;
        logic               loop_active;
        logic               tripped;
        logic [31:0]        trip_elapsed_us;
    } spc_out_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? TIMER_MAX : s[31:0];
    endfunction

endpackage

// ===== src/spc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_cfg_regs
// Configuration register file; writes beyond the last index are dropped.
// ----------------------------------------------------------------------------
module spc_cfg_regs
    import spc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output spc_cfg_t              cfg
);

    spc_cfg_t cfg_reg;
    spc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_BLADE_FOLD: cfg_next.blade_fold = wr_data[0];
                REG_DEADBAND:   cfg_next.deadband   = wr_data[14:0];
                REG_HYSTERESIS: cfg_next.hysteresis = wr_data[14:0];
                REG_PROP_GAIN:  cfg_next.prop_gain  = wr_data[15:0];
                REG_DAMP_GAIN:  cfg_next.damp_gain  = wr_data[15:0];
                REG_SPEED_LIM:
                begin
                    cfg_next.speed_max = wr_data[15:0];
                    cfg_next.min_kick  = wr_data[31:16];
                end
                REG_SETTLE_LIM:
                begin
                    cfg_next.settle_pos_tol = wr_data[15:0];
                    cfg_next.settle_vel_tol = wr_data[31:16];
                    cfg_next.settle_hold_us = wr_data[63:32];
                end
                REG_TRIP_LIM:
                begin
                    cfg_next.trip_err     = wr_data[15:0];
                    cfg_next.trip_time_us = wr_data[47:16];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/spc_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_track
// Error wrap/fold, settle and trip timers, direction latch, PD products.
// Holds all loop state; state moves only when the stage advances.
// ----------------------------------------------------------------------------
module spc_track
    import spc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  spc_cfg_t cfg,
    input  spc_in_t  item,
    output spc_mid_t mid
);

    dir_t        dir_reg,          dir_next;
    logic [31:0] settle_timer_reg, settle_timer_next;
    logic [31:0] trip_timer_reg,   trip_timer_next;
    logic        trip_flag_reg,    trip_flag_next;

    logic [15:0]        diff;
    logic signed [16:0] err_wide;
    logic signed [16:0] err_fold;
    logic signed [15:0] err;
    logic signed [16:0] aerr_wide;
    logic [15:0]        aerr;
    logic signed [24:0] vel_wide;
    logic signed [24:0] avel_wide;
    logic [23:0]        avel;
    dir_t               want;
    logic               in_deadband;

    always_comb
    begin
        diff     = item.target_angle - item.measured_angle;
        err_wide = {diff[15], diff};
        err_fold = err_wide;
        if (cfg.blade_fold)
        begin
            if (err_wide > QUARTER_TURN)
                err_fold = err_wide - HALF_TURN;
            else if (err_wide < -QUARTER_TURN)
                err_fold = err_wide + HALF_TURN;
        end
        err       = err_fold[15:0];
        aerr_wide = err_fold[16] ? -err_fold : err_fold;
        aerr      = aerr_wide[15:0];
        vel_wide  = {item.shaft_velocity[23], item.shaft_velocity};
        avel_wide = vel_wide[24] ? -vel_wide : vel_wide;
        avel      = avel_wide[23:0];
        want      = (err > 16'sd0) ? DIR_FWD : DIR_REV;
        in_deadband = aerr < {1'b0, cfg.deadband};
    end

    always_comb
    begin
        dir_next          = dir_reg;
        settle_timer_next = '0;
        trip_timer_next   = '0;
        trip_flag_next    = trip_flag_reg;
        mid               = '0;
        mid.dir           = dir_reg;
        mid.zero_cmd      = 1'b1;

        if (item.encoder_ok)
        begin
            if (aerr < cfg.settle_pos_tol && avel < {8'd0, cfg.settle_vel_tol})
                settle_timer_next = sat_add32(settle_timer_reg, item.elapsed_us);

            if (aerr > cfg.trip_err)
            begin
                trip_timer_next = sat_add32(trip_timer_reg, item.elapsed_us);
                if (trip_timer_next >= cfg.trip_time_us)
                    trip_flag_next = 1'b1;
            end

            if (in_deadband)
                dir_next = DIR_NONE;
            else if (dir_reg != DIR_FWD && dir_reg != DIR_REV)
                dir_next = want;
            else if (want != dir_reg)
            begin
                if (aerr < {1'b0, cfg.hysteresis})
                    dir_next = want;
                else
                    mid.blocked = 1'b1;
            end

            mid.zero_cmd        = in_deadband;
            mid.dir             = dir_next;
            mid.position_err    = err;
            mid.settled         = settle_timer_next >= cfg.settle_hold_us;
            mid.loop_active     = 1'b1;
            mid.trip_elapsed_us = trip_timer_next;
            mid.prop_prod       = 33'($signed({1'b0, cfg.prop_gain})) * 33'(err);
            mid.damp_prod       = 41'($signed({1'b0, cfg.damp_gain}))
                                * 41'(item.shaft_velocity);
        end
        mid.tripped = trip_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg          <= DIR_NONE;
            settle_timer_reg <= '0;
            trip_timer_reg   <= '0;
            trip_flag_reg    <= 1'b0;
        end
        else if (advance)
        begin
            dir_reg          <= dir_next;
            settle_timer_reg <= settle_timer_next;
            trip_timer_reg   <= trip_timer_next;
            trip_flag_reg    <= trip_flag_next;
        end
    end

endmodule

// ===== src/spc_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_shape
// PD sum with floor shifts, reversal block, magnitude clamp, minimum kick.
// ----------------------------------------------------------------------------
module spc_shape
    import spc_pkg::*;
(
    input  spc_cfg_t cfg,
    input  spc_mid_t mid,
    output spc_out_t res
);

    logic signed [33:0] prop_term;
    logic signed [33:0] damp_term;
    logic signed [33:0] cmd_sum;
    logic signed [33:0] cmd_dir;
    logic signed [33:0] cmd_clamp;
    logic signed [33:0] cmd_abs;
    logic signed [33:0] cmd_final;
    logic signed [33:0] smax;
    logic signed [33:0] kick;

    always_comb
    begin
        // arithmetic shift of a two's complement value floors
        prop_term = 34'($signed(mid.prop_prod) >>> 16);
        damp_term = 34'($signed(mid.damp_prod) >>> 8);
        cmd_sum   = prop_term - damp_term;
        smax      = $signed({18'd0, cfg.speed_max});
        kick      = $signed({18'd0, cfg.min_kick});

        cmd_dir = cmd_sum;
        if (mid.blocked)
        begin
            if (mid.dir == DIR_FWD && cmd_sum < 34'sd0)
                cmd_dir = -cmd_sum;
            else if (mid.dir == DIR_REV && cmd_sum > 34'sd0)
                cmd_dir = -cmd_sum;
        end

        if (cmd_dir > smax)
            cmd_clamp = smax;
        else if (cmd_dir < -smax)
            cmd_clamp = -smax;
        else
            cmd_clamp = cmd_dir;

        cmd_abs = (cmd_clamp < 34'sd0) ? -cmd_clamp : cmd_clamp;
        if (cmd_abs < kick)
            cmd_final = (mid.dir == DIR_FWD) ? kick : -kick;
        else
            cmd_final = cmd_clamp;

        res.speed_ref       = mid.zero_cmd ? 17'sd0 : cmd_final[16:0];
        res.position_err    = mid.position_err;
        res.settled         = mid.settled;
        res.loop_active     = mid.loop_active;
        res.tripped         = mid.tripped;
        res.trip_elapsed_us = mid.trip_elapsed_us;
    end

endmodule

// ===== src/shaft_park_position_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shaft_park_position_controller_core
// PD shaft park position loop with deadband, hysteresis and trip timers.
// ----------------------------------------------------------------------------
// One tick in, one speed command out. The core takes a tick on every clock
// cycle unless the output side stalls. The tick lands in the input register,
// and one combinational pass (error, timers, direction latch, gain products,
// command shaping) feeds the output register. The direction latch and both
// timers update as the output register loads, so back-to-back ticks see
// each other's state without bubbles. A stalled master side holds the tick
// in the input register; up to two ticks are buffered before s_tready drops.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while no tick is in flight. Indices beyond 7 are ignored.
// The trip flag stays set until reset. When encoder_ok is low the command,
// error, settled, loop_active and timers read zero; tripped still shows the
// sticky flag.
// ----------------------------------------------------------------------------
module shaft_park_position_controller_core
    import spc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // tdata: target_angle[15:0], measured_angle[31:16], shaft_velocity[55:32],
    //        elapsed_us[71:56]
    // tuser: encoder_ok
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,

    // tdata: speed_ref[16:0], position_err[32:17], settled[33], tripped[34],
    //        trip_elapsed_us[66:35], zero pad[71:67]
    // tuser: loop_active
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    spc_cfg_t cfg;

    // pipeline registers
    logic     in_valid_reg;
    spc_in_t  in_item_reg;
    logic     out_valid_reg;
    spc_out_t out_reg;

    spc_in_t  in_item;
    spc_mid_t mid_next;
    spc_out_t out_next;

    logic out_free;
    logic in_free;
    logic track_fire;

    assign cfg_ready = 1'b1;

    spc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // stage ready chain: a stage takes new data when empty or draining
    assign out_free   = !out_valid_reg || m_tready;
    assign in_free    = !in_valid_reg  || out_free;
    assign s_tready   = in_free;
    assign track_fire = in_valid_reg  && out_free;

    assign in_item.target_angle   = s_tdata[15:0];
    assign in_item.measured_angle = s_tdata[31:16];
    assign in_item.shaft_velocity = s_tdata[55:32];
    assign in_item.elapsed_us     = s_tdata[71:56];
    assign in_item.encoder_ok     = s_tuser;

    spc_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (track_fire),
        .cfg     (cfg),
        .item    (in_item_reg),
        .mid     (mid_next)
    );

    spc_shape u_shape (
        .cfg (cfg),
        .mid (mid_next),
        .res (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_free)
            in_item_reg <= in_item;
        if (track_fire)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.trip_elapsed_us, out_reg.tripped, out_reg.settled,
                       out_reg.position_err, out_reg.speed_ref};
    assign m_tuser  = out_reg.loop_active;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shaft park position controller core.
// ----------------------------------------------------------------------------
// Ticks go in on the slave stream, speed commands come back on the master
// stream. A scoreboard object keeps its own copy of the registers, the
// direction latch, both timers and the sticky trip flag. It predicts every
// result when the tick transfer happens and checks results in order.
// Stimulus runs in this order:
//   - directed ticks: field extremes, encoder dropout, deadband, hysteresis,
//     blocked reversal, two-blade folding, kick above max speed
//   - random park approaches with random register settings
//   - a short full-rate run of long ticks
// Both sides stall at random between register updates, bar the last random phase and the soak.
// ----------------------------------------------------------------------------
module tb_top
    import spc_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SOAK_TICKS   = 40;      // back-to-back 0xFFFF us ticks

    // ------------------------------------------------------------------------
    // Predictor and result checker
    // ------------------------------------------------------------------------
    class park_scoreboard;
        spc_cfg_t    cfg;
        dir_t        heading;
        logic [31:0] settle_us;
        logic [31:0] trip_us;
        logic        trip_latched;
        spc_out_t    predicted_cmds[$];
        int          mismatch_count;

        function new();
            cfg            = '0;
            heading        = DIR_NONE;
            settle_us      = '0;
            trip_us        = '0;
            trip_latched   = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return predicted_cmds.size();
        endfunction

        // Unknown indices fall through and change nothing.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BLADE_FOLD: cfg.blade_fold = val[0];
                REG_DEADBAND:   cfg.deadband   = val[14:0];
                REG_HYSTERESIS: cfg.hysteresis = val[14:0];
                REG_PROP_GAIN:  cfg.prop_gain  = val[15:0];
                REG_DAMP_GAIN:  cfg.damp_gain  = val[15:0];
                REG_SPEED_LIM:  {cfg.min_kick, cfg.speed_max} = val[31:0];
                REG_SETTLE_LIM: {cfg.settle_hold_us, cfg.settle_vel_tol,
                                 cfg.settle_pos_tol} = val;
                REG_TRIP_LIM:   {cfg.trip_time_us, cfg.trip_err} = val[47:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] timer_add(logic [31:0] acc, logic [15:0] dt);
            longint sum;
            sum = longint'(acc) + longint'(dt);
            return (sum > longint'(TIMER_MAX)) ? TIMER_MAX : sum[31:0];
        endfunction

        // Advance the loop state by one tick and queue the command it gives.
        function void note_tick(spc_in_t t);
            spc_out_t    r;
            logic [15:0] d;
            int          err;
            int          aerr;
            int          vel;
            int          avel;
            longint      cmd;
            longint      acmd;
            longint      smax;
            longint      kick;
            bit          blocked;
            dir_t        want;

            r       = '0;
            blocked = 1'b0;

            // Encoder dropout: timers clear, latch kept, only the trip flag shows
            if (!t.encoder_ok)
            begin
                settle_us  = '0;
                trip_us    = '0;
                r.tripped  = trip_latched;
                predicted_cmds.push_back(r);
                return;
            end

            d   = t.target_angle - t.measured_angle;
            err = $signed(d);
            if (cfg.blade_fold)
            begin
                if (err > int'(QUARTER_TURN))
                    err -= int'(HALF_TURN);
                else if (err < -int'(QUARTER_TURN))
                    err += int'(HALF_TURN);
            end
            vel  = t.shaft_velocity;
            aerr = (err < 0) ? -err : err;
            avel = (vel < 0) ? -vel : vel;

            if (aerr < int'(cfg.settle_pos_tol) && avel < int'(cfg.settle_vel_tol))
                settle_us = timer_add(settle_us, t.elapsed_us);
            else
                settle_us = '0;

            if (aerr > int'(cfg.trip_err))
            begin
                trip_us = timer_add(trip_us, t.elapsed_us);
                if (trip_us >= cfg.trip_time_us)
                    trip_latched = 1'b1;
            end
            else
            begin
                trip_us = '0;
            end

            r.position_err    = err[15:0];
            r.settled         = (settle_us >= cfg.settle_hold_us);
            r.loop_active     = 1'b1;
            r.tripped         = trip_latched;
            r.trip_elapsed_us = trip_us;

            // Inside the deadband: zero command, latch released
            if (aerr < int'(cfg.deadband))
            begin
                heading = DIR_NONE;
                predicted_cmds.push_back(r);
                return;
            end

            // Zero error lands here as a reverse request
            want = (err > 0) ? DIR_FWD : DIR_REV;
            if (heading != DIR_FWD && heading != DIR_REV)
                heading = want;
            else if (want != heading)
            begin
                if (aerr < int'(cfg.hysteresis))
                    heading = want;
                else
                    blocked = 1'b1;
            end

            // Both terms floored: arithmetic shift of a signed 64-bit product
            cmd = ((longint'(cfg.prop_gain) * err) >>> 16)
                - ((longint'(cfg.damp_gain) * vel) >>> 8);

            // A blocked reversal keeps pushing the latched way
            if (blocked)
            begin
                if (heading == DIR_FWD && cmd < 0)
                    cmd = -cmd;
                else if (heading == DIR_REV && cmd > 0)
                    cmd = -cmd;
            end

            smax = longint'(cfg.speed_max);
            kick = longint'(cfg.min_kick);
            if (cmd > smax)
                cmd = smax;
            else if (cmd < -smax)
                cmd = -smax;

            // Kick wins over the clamp when it is the larger of the two
            acmd = (cmd < 0) ? -cmd : cmd;
            if (acmd < kick)
                cmd = (heading == DIR_FWD) ? kick : -kick;

            r.speed_ref = cmd[16:0];
            predicted_cmds.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(spc_out_t got);
            spc_out_t want;
            if (predicted_cmds.size() == 0)
            begin
                mismatch_count++;
                $error("result transfer with no tick outstanding");
                return;
            end
            want = predicted_cmds.pop_front();
            compare_field("speed_ref",       want.speed_ref,       got.speed_ref);
            compare_field("position_err",    want.position_err,    got.position_err);
            compare_field("settled",         want.settled,         got.settled);
            compare_field("loop_active",     want.loop_active,     got.loop_active);
            compare_field("tripped",         want.tripped,         got.tripped);
            compare_field("trip_elapsed_us", want.trip_elapsed_us, got.trip_elapsed_us);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // target[15:0] measured[31:16] velocity[55:32] elapsed[71:56]
    logic                  s_tuser;    // encoder_ok
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // speed_ref[16:0] position_err[32:17] settled[33]
                                       // tripped[34] trip_elapsed_us[66:35]
    logic                  m_tuser;    // loop_active
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    park_scoreboard sb;
    spc_out_t       seen_cmd;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             cycle_count;

    shaft_park_position_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: ready decided per cycle at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: every accepted transfer checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_cmd.speed_ref       = m_tdata[16:0];
            seen_cmd.position_err    = m_tdata[32:17];
            seen_cmd.settled         = m_tdata[33];
            seen_cmd.tripped         = m_tdata[34];
            seen_cmd.trip_elapsed_us = m_tdata[66:35];
            seen_cmd.loop_active     = m_tuser;
            sb.check_result(seen_cmd);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("shaft_park_position_controller_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers (all called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    function automatic spc_in_t tick_of(logic [15:0] tgt, logic [15:0] meas,
                                        logic signed [23:0] vel, logic enc,
                                        logic [15:0] dt);
        spc_in_t t;
        t.target_angle   = tgt;
        t.measured_angle = meas;
        t.shaft_velocity = vel;
        t.encoder_ok     = enc;
        t.elapsed_us     = dt;
        return t;
    endfunction

    // valid stays up between back-to-back transfers; only idle gaps drop it
    task automatic send_tick(input spc_in_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.elapsed_us, t.shaft_velocity, t.measured_angle, t.target_angle};
        s_tuser  <= t.encoder_ok;
        do @(posedge clk); while (!s_tready);
        sb.note_tick(t);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    // Full register load; bits above each field carry junk, plus one unmapped index
    task automatic apply_setting(input spc_cfg_t c);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_BLADE_FOLD, {junk[63:1],  c.blade_fold});
        write_reg(REG_DEADBAND,   {junk[63:15], c.deadband});
        write_reg(REG_HYSTERESIS, {junk[63:15], c.hysteresis});
        write_reg(REG_PROP_GAIN,  {junk[63:16], c.prop_gain});
        write_reg(REG_DAMP_GAIN,  {junk[63:16], c.damp_gain});
        write_reg(REG_SPEED_LIM,  {junk[63:32], c.min_kick, c.speed_max});
        write_reg(REG_SETTLE_LIM, {c.settle_hold_us, c.settle_vel_tol, c.settle_pos_tol});
        write_reg(REG_TRIP_LIM,   {junk[63:48], c.trip_time_us, c.trip_err});
        write_reg(CFG_IDX_W'($urandom_range(8, 15)), ~junk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off the sender until every result is back, then let the pipe drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_val(input logic [31:0] hi, input logic [31:0] typ);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return hi;
            2, 3:    return $urandom & hi;
            default: return $urandom_range(typ, 0);
        endcase
    endfunction

    // Trip time stays huge unless tripping is allowed: the flag never clears
    function automatic spc_cfg_t random_setting(input bit allow_trip);
        spc_cfg_t c;
        c.blade_fold     = 1'($urandom);
        c.deadband       = 15'(pick_val(32'h7FFF, 1500));
        c.hysteresis     = 15'(pick_val(32'h7FFF, 8000));
        c.prop_gain      = 16'(pick_val(32'hFFFF, 4096));
        c.damp_gain      = 16'(pick_val(32'hFFFF, 512));
        c.speed_max      = 16'(pick_val(32'hFFFF, 30000));
        c.min_kick       = 16'(pick_val(32'hFFFF, 400));
        c.settle_pos_tol = 16'(pick_val(32'hFFFF, 1500));
        c.settle_vel_tol = 16'(pick_val(32'hFFFF, 2000));
        c.settle_hold_us = pick_val(32'hFFFF_FFFF, 3000);
        c.trip_err       = 16'(pick_val(32'hFFFF, 16000));
        c.trip_time_us   = allow_trip ? pick_val(32'hFFFF_FFFF, 20000)
                                      : (32'h8000_0000 | $urandom);
        return c;
    endfunction

    // Park approaches: a fixed target, error decaying with overshoot and jitter,
    // mixed with fully random ticks
    task automatic run_park_moves(input int n_ticks);
        spc_in_t     t;
        int          left;
        int          seq_left;
        int          perr;
        int          jitter;
        logic [15:0] tgt;
        left = n_ticks;
        while (left > 0)
        begin
            tgt      = 16'($urandom);
            perr     = int'($urandom_range(0, 65535)) - 32768;
            seq_left = $urandom_range(8, 40);
            while (seq_left > 0 && left > 0)
            begin
                jitter = int'($urandom_range(0, 200)) - 100;
                if ($urandom_range(0, 99) < 10)
                begin
                    t.target_angle   = 16'($urandom);
                    t.measured_angle = 16'($urandom);
                    t.shaft_velocity = 24'($urandom);
                    t.encoder_ok     = 1'($urandom);
                    t.elapsed_us     = 16'($urandom);
                end
                else
                begin
                    t.target_angle   = tgt;
                    t.measured_angle = tgt - 16'(perr);
                    t.shaft_velocity = ($urandom_range(0, 19) == 0) ? 24'($urandom)
                                                                    : 24'(perr * 4 + jitter);
                    t.encoder_ok     = ($urandom_range(0, 99) < 94);
                    t.elapsed_us     = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(20, 1500));
                    case ($urandom_range(0, 9))
                        0:       perr = -(perr / 2);    // overshoot
                        1:       perr = perr + jitter;
                        default: perr = (perr * 3) / 4;
                    endcase
                end
                send_tick(t);
                left--;
                seq_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        spc_cfg_t c;

        sb            = new();
        cycle_count   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 45;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Nominal tuning for the directed ticks; trip time out of reach
        c                = '0;
        c.deadband       = 15'd100;
        c.hysteresis     = 15'd2000;
        c.prop_gain      = 16'h0400;
        c.damp_gain      = 16'h0080;
        c.speed_max      = 16'd20000;
        c.min_kick       = 16'd50;
        c.settle_pos_tol = 16'd300;
        c.settle_vel_tol = 16'd200;
        c.settle_hold_us = 32'd500;
        c.trip_err       = 16'd8000;
        c.trip_time_us   = 32'h9000_0000;
        apply_setting(c);

        send_tick(tick_of(16'hFFFF, 16'h0000,  24'sh7FFFFF, 1'b0, 16'hFFFF)); // encoder lost
        send_tick(tick_of(16'h0000, 16'h8000,  24'sh800000, 1'b1, 16'hFFFF)); // -half turn
        send_tick(tick_of(16'h7FFF, 16'h0000,  24'sh7FFFFF, 1'b1, 16'h0000)); // blocked flip
        send_tick(tick_of(16'hFFFF, 16'h0000,  24'sd0,      1'b1, 16'd100));  // deadband
        send_tick(tick_of(16'h1770, 16'h0000,  24'sd0,      1'b1, 16'd100));  // latch fwd
        send_tick(tick_of(16'h0000, 16'h1770,  24'sd0,      1'b1, 16'd100));  // blocked
        send_tick(tick_of(16'h0000, 16'h05DC,  24'sd0,      1'b1, 16'd100));  // reversal ok
        repeat (3)
            send_tick(tick_of(16'h1000, 16'h0FCE, 24'sd10, 1'b1, 16'd200));   // settling
        send_tick(tick_of(16'h1000, 16'h0FCE,  24'sd10,     1'b0, 16'd200));  // dropout clears
        send_tick(tick_of(16'h1000, 16'h0FCE, -24'sd10,     1'b1, 16'd200));
        send_tick(tick_of(16'h2000, 16'h1000,  24'sh7FFFFF, 1'b1, 16'd300));  // clamp negative
        send_tick(tick_of(16'h0000, 16'h0000,  24'sd0,      1'b1, 16'hFFFF));
        repeat (2)
            send_tick(tick_of(16'h2710, 16'h0000, 24'sd0, 1'b1, 16'hFFFF));   // trip timer runs
        wait_idle();

        // Two blades, no deadband, kick above max speed, gains at full scale
        c.blade_fold     = 1'b1;
        c.deadband       = 15'd0;
        c.hysteresis     = 15'h7FFF;
        c.prop_gain      = 16'hFFFF;
        c.damp_gain      = 16'hFFFF;
        c.speed_max      = 16'h0100;
        c.min_kick       = 16'h0400;
        c.settle_pos_tol = 16'hFFFF;
        c.settle_vel_tol = 16'hFFFF;
        c.settle_hold_us = 32'hFFFF_FFFF;
        c.trip_err       = 16'd0;
        c.trip_time_us   = 32'hFFFF_FFFF;
        apply_setting(c);

        send_tick(tick_of(16'h1234, 16'h1234, 24'sd0,      1'b1, 16'd10));    // zero error
        send_tick(tick_of(16'h4001, 16'h0000, 24'sd0,      1'b1, 16'd10));    // folds down
        send_tick(tick_of(16'h0000, 16'h4001, 24'sd0,      1'b1, 16'd10));    // folds up
        send_tick(tick_of(16'h4000, 16'h0000, 24'sd0,      1'b1, 16'd10));    // quarter, kept
        send_tick(tick_of(16'h0000, 16'h4000, 24'sd0,      1'b1, 16'd10));
        send_tick(tick_of(16'h7FFF, 16'h0000, 24'sd0,      1'b1, 16'd10));
        send_tick(tick_of(16'h8000, 16'h0000, 24'sd0,      1'b1, 16'd10));
        send_tick(tick_of(16'h03E8, 16'h0000, 24'sh7FFFFF, 1'b1, 16'd10));
        send_tick(tick_of(16'h03E8, 16'h0000, 24'sh800000, 1'b1, 16'd10));
        wait_idle();

        // Random phase: sender-light/receiver-heavy, swapped, then no stalls.
        // Only the last one may set the sticky trip flag.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 22 : 0;
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                apply_setting(random_setting(phase == 2));
                run_park_moves(45);
                wait_idle();
            end
        end

        // Full-rate run of long ticks with wide-open settle window
        c                = '0;
        c.prop_gain      = 16'h0100;
        c.speed_max      = 16'hFFFF;
        c.settle_pos_tol = 16'hFFFF;
        c.settle_vel_tol = 16'hFFFF;
        c.settle_hold_us = 32'hFFFF_FFFF;
        c.trip_time_us   = 32'hFFFF_FFFF;
        apply_setting(c);
        for (int n = 0; n < SOAK_TICKS; n++)
            send_tick(tick_of(16'h03E8, 16'h0000, 24'sd0, 1'b1, 16'hFFFF));
        wait_idle();

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("shaft_park_position_controller_core verification clean");
        else
            $display("shaft_park_position_controller_core verification failed");
        $finish;
    end

endmodule

// ===== shaft_park_position_controller_core.f =====
src/spc_pkg.sv
src/spc_cfg_regs.sv
src/spc_track.sv
src/spc_shape.sv
src/shaft_park_position_controller_core.sv
tb/tb_top.sv
